// ===== design/rpp2d_pkg.sv =====
// package: shared constants, register indexes and unit-vector helpers
`timescale 1ns / 1ps
`default_nettype none

package rpp2d_pkg;

    localparam int UNIT_W          = 16;
    localparam int UNIT_FRAC       = 14;
    localparam int Q_FRAC          = 16;
    localparam int ROT_W           = 3 * UNIT_W;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 48;
    localparam int PROD_LIMIT_BITS = 63;
    localparam longint SENTINEL_MAG = 64'sd6553600;
    localparam logic [ROT_W-1:0] NORMAL_RESET = 48'd16384;

    localparam logic CMD_POINT = 1'b0;
    localparam logic CMD_DIR   = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PLANE_NORMAL   = 3'd0,
        REG_PLANE_OFFSET   = 3'd1,
        REG_U_ROW_ROTATION = 3'd2,
        REG_U_ROW_OFFSET   = 3'd3,
        REG_V_ROW_ROTATION = 3'd4,
        REG_V_ROW_OFFSET   = 3'd5
    } cfg_reg_t;

    typedef enum logic [1:0] {
        AXIS_X = 2'd0,
        AXIS_Y = 2'd1,
        AXIS_Z = 2'd2
    } axis_t;

    function automatic logic signed [UNIT_W-1:0] unit_at(input logic [ROT_W-1:0] packed_v,
                                                         input axis_t axis);
        logic signed [UNIT_W-1:0] res;
        case (axis)
            AXIS_X:  res = packed_v[3*UNIT_W-1:2*UNIT_W];
            AXIS_Y:  res = packed_v[2*UNIT_W-1:UNIT_W];
            AXIS_Z:  res = packed_v[UNIT_W-1:0];
            default: res = '0;
        endcase
        return res;
    endfunction

    function automatic axis_t axis_of(input int i);
        axis_t res;
        case (i)
            0:       res = AXIS_X;
            1:       res = AXIS_Y;
            default: res = AXIS_Z;
        endcase
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== design/rpp2d_if.sv =====
// interfaces: ray input, projection output and configuration write channels
`timescale 1ns / 1ps
`default_nettype none

interface rpp2d_ray_if #(parameter int COORD_WIDTH = 32);
    logic                          valid;
    logic                          ready;
    logic                          command;
    logic signed [COORD_WIDTH-1:0] origin_x;
    logic signed [COORD_WIDTH-1:0] origin_y;
    logic signed [COORD_WIDTH-1:0] origin_z;
    logic signed [COORD_WIDTH-1:0] second_x;
    logic signed [COORD_WIDTH-1:0] second_y;
    logic signed [COORD_WIDTH-1:0] second_z;

    modport source (output valid, command, origin_x, origin_y, origin_z,
                    second_x, second_y, second_z, input ready);
    modport sink (input valid, command, origin_x, origin_y, origin_z,
                  second_x, second_y, second_z, output ready);
endinterface

interface rpp2d_proj_if #(parameter int COORD_WIDTH = 32);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] plane_u;
    logic signed [COORD_WIDTH-1:0] plane_v;
    logic                          miss;

    modport source (output valid, plane_u, plane_v, miss, input ready);
    modport sink (input valid, plane_u, plane_v, miss, output ready);
endinterface

interface rpp2d_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [47:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== design/rpp2d_front.sv =====
// front end: ray direction, normal dot products and miss classification
`timescale 1ns / 1ps
`default_nettype none

module rpp2d_front
    import rpp2d_pkg::*;
#(
    parameter int COORD_WIDTH = 32
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    rpp2d_ray_if.sink                          ray,
    input  wire logic [ROT_W-1:0]              plane_normal,
    input  wire logic signed [COORD_WIDTH-1:0] plane_offset,
    output logic                               ent_valid,
    input  wire logic                          ent_ready,
    output logic [8*COORD_WIDTH+10:0]          ent_data
);

    localparam int W  = COORD_WIDTH;
    localparam int PW = W + UNIT_W;
    localparam int TW = W + 2;
    localparam int SW = W + 4;
    localparam int NW = W + 5;
    localparam logic signed [W-1:0] C_MAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] C_MIN = {1'b1, {(W-1){1'b0}}};

    logic signed [W-1:0]  in_o [3];
    logic signed [W-1:0]  in_s [3];
    logic signed [W:0]    diff [3];
    logic signed [W-1:0]  dsat [3];
    logic                 en;

    logic                 s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic                 s1_cmd_reg, s2_cmd_reg;
    logic signed [W-1:0]  s1_o_reg [3];
    logic signed [W-1:0]  s1_d_reg [3];
    logic signed [W-1:0]  s2_o_reg [3];
    logic signed [W-1:0]  s2_d_reg [3];
    logic signed [TW-1:0] s2_to_reg [3];
    logic signed [TW-1:0] s2_td_reg [3];
    logic signed [PW-1:0] prod_o [3];
    logic signed [PW-1:0] prod_d [3];
    logic signed [SW-1:0] dn;
    logic signed [SW-1:0] dot_o;
    logic signed [NW-1:0] num;
    logic [NW-1:0]        nm;
    logic [SW-1:0]        dm;
    logic                 miss_c;
    logic [8*W+10:0]      ent_data_reg;

    assign in_o[0] = ray.origin_x;
    assign in_o[1] = ray.origin_y;
    assign in_o[2] = ray.origin_z;
    assign in_s[0] = ray.second_x;
    assign in_s[1] = ray.second_y;
    assign in_s[2] = ray.second_z;

    assign en        = !s3_valid_reg || ent_ready;
    assign ray.ready = en;
    assign ent_valid = s3_valid_reg;
    assign ent_data  = ent_data_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            diff[i] = (W+1)'(in_s[i]) - (W+1)'(in_o[i]);
            if (diff[i] > (W+1)'(C_MAX))
                dsat[i] = C_MAX;
            else if (diff[i] < (W+1)'(C_MIN))
                dsat[i] = C_MIN;
            else
                dsat[i] = W'(diff[i]);
            prod_o[i] = unit_at(plane_normal, axis_of(i)) * s1_o_reg[i];
            prod_d[i] = unit_at(plane_normal, axis_of(i)) * s1_d_reg[i];
        end
    end

    always_comb
    begin
        dn    = SW'(s2_td_reg[0]) + SW'(s2_td_reg[1]) + SW'(s2_td_reg[2]);
        dot_o = SW'(s2_to_reg[0]) + SW'(s2_to_reg[1]) + SW'(s2_to_reg[2]);
        num   = NW'(plane_offset) - NW'(dot_o);
        nm    = num[NW-1] ? NW'(-num) : NW'(num);
        dm    = dn[SW-1] ? SW'(-dn) : SW'(dn);
        miss_c = (dn == '0) || ((s2_cmd_reg == CMD_POINT) && !dn[SW-1]) ||
                 ((num != '0) && (num[NW-1] != dn[SW-1]));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= ray.valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_cmd_reg <= ray.command;
            s2_cmd_reg <= s1_cmd_reg;
            for (int i = 0; i < 3; i++)
            begin
                s1_o_reg[i]  <= in_o[i];
                s1_d_reg[i]  <= (ray.command == CMD_DIR) ? in_s[i] : dsat[i];
                s2_o_reg[i]  <= s1_o_reg[i];
                s2_d_reg[i]  <= s1_d_reg[i];
                s2_to_reg[i] <= TW'(prod_o[i] >>> UNIT_FRAC);
                s2_td_reg[i] <= TW'(prod_d[i] >>> UNIT_FRAC);
            end
            ent_data_reg <= {s2_cmd_reg, miss_c, nm, dm,
                             s2_o_reg[0], s2_o_reg[1], s2_o_reg[2],
                             s2_d_reg[0], s2_d_reg[1], s2_d_reg[2]};
        end
    end

endmodule

`default_nettype wire

// ===== design/rpp2d_queue.sv =====
// two-entry queue between front and back end
`timescale 1ns / 1ps
`default_nettype none

module rpp2d_queue
    import rpp2d_pkg::*;
#(
    parameter int DATA_W = 267
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [DATA_W-1:0] in_data,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [DATA_W-1:0]      out_data
);

    logic [DATA_W-1:0] mem [2];
    logic              wr_ptr_reg, rd_ptr_reg;
    logic [1:0]        count_reg;
    logic [1:0]        count_next;
    logic              push, pop;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_data  = mem[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 2'd1;
        else if (pop && !push)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= in_data;
    end

endmodule

`default_nettype wire

// ===== design/rpp2d_back.sv =====
// back end: pipelined divide for t, hit point and plane-local projection
`timescale 1ns / 1ps
`default_nettype none

module rpp2d_back
    import rpp2d_pkg::*;
#(
    parameter int COORD_WIDTH = 32
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          ent_valid,
    output logic                               ent_ready,
    input  wire logic [8*COORD_WIDTH+10:0]     ent_data,
    input  wire logic [ROT_W-1:0]              u_row_rotation,
    input  wire logic signed [COORD_WIDTH-1:0] u_row_offset,
    input  wire logic [ROT_W-1:0]              v_row_rotation,
    input  wire logic signed [COORD_WIDTH-1:0] v_row_offset,
    rpp2d_proj_if.source                       proj
);

    localparam int W     = COORD_WIDTH;
    localparam int PW    = W + UNIT_W;
    localparam int TW    = W + 2;
    localparam int SW    = W + 4;
    localparam int NW    = W + 5;
    localparam int OW    = W + 5;
    localparam int RW    = 2 * W + 21;
    localparam int DS    = W - 1;
    localparam int HW    = (W - 1) / 2;
    localparam int HIW   = W - 1 - HW;
    localparam int PRODW = 2 * W - 1;
    localparam int TERMW = PRODW - Q_FRAC;
    localparam int HSW   = 2 * W + 2;
    localparam logic signed [W-1:0] C_MAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] C_MIN = {1'b1, {(W-1){1'b0}}};
    localparam logic signed [W-1:0] SENT_POS =
        (SENTINEL_MAG <= ((64'sd1 <<< (W - 1)) - 64'sd1)) ? W'(SENTINEL_MAG) : C_MAX;
    localparam logic signed [W-1:0] SENT_NEG =
        (SENTINEL_MAG <= (64'sd1 <<< (W - 1))) ? W'(-SENTINEL_MAG) : C_MIN;

    logic                en;
    logic                e_cmd, e_miss;
    logic [NW-1:0]       e_nm;
    logic [SW-1:0]       e_dm;
    logic signed [W-1:0] e_o [3];
    logic signed [W-1:0] e_d [3];

    // divider pipeline, index 0 is the setup stage
    logic                valid_reg [DS+1];
    logic                cmd_reg   [DS+1];
    logic                miss_reg  [DS+1];
    logic                sat_reg   [DS+1];
    logic [RW-1:0]       r_reg     [DS+1];
    logic [W-2:0]        q_reg     [DS+1];
    logic [SW-1:0]       dm_reg    [DS+1];
    logic signed [W-1:0] o_reg     [DS+1][3];
    logic signed [W-1:0] d_reg     [DS+1][3];
    logic [RW-1:0]       div_trial [1:DS];
    logic                div_ge    [1:DS];
    logic [RW-1:0]       n_init;
    logic                n_sat;
    logic [W-2:0]        t_val;

    logic                m1_valid_reg, m2_valid_reg, m3_valid_reg, u1_valid_reg;
    logic                m1_cmd_reg, m2_cmd_reg, m3_cmd_reg, u1_cmd_reg;
    logic                m1_miss_reg, m2_miss_reg, m3_miss_reg, u1_miss_reg;
    logic [W-1:0]        am [3];
    logic [HW+W-1:0]     m1_plo_reg [3];
    logic [HIW+W-1:0]    m1_phi_reg [3];
    logic                m1_neg_reg [3];
    logic signed [W-1:0] m1_o_reg   [3];
    logic [PRODW-1:0]    prod       [3];
    logic [TERMW-1:0]    m2_term_reg [3];
    logic                m2_ovf_reg  [3];
    logic                m2_neg_reg  [3];
    logic signed [W-1:0] m2_o_reg    [3];
    logic signed [HSW-1:0] h_full    [3];
    logic signed [W-1:0] h_c         [3];
    logic signed [W-1:0] m3_h_reg    [3];
    logic signed [PW-1:0] pu [3];
    logic signed [PW-1:0] pv [3];
    logic signed [TW-1:0] u1_tu_reg [3];
    logic signed [TW-1:0] u1_tv_reg [3];
    logic signed [OW-1:0] sum_u, sum_v;
    logic signed [W-1:0]  u_sat, v_sat;

    logic                 out_valid_reg;
    logic signed [W-1:0]  plane_u_reg, plane_v_reg;
    logic                 out_miss_reg;

    assign {e_cmd, e_miss, e_nm, e_dm, e_o[0], e_o[1], e_o[2],
            e_d[0], e_d[1], e_d[2]} = ent_data;

    assign en         = !out_valid_reg || proj.ready;
    assign ent_ready  = en;
    assign proj.valid = out_valid_reg;
    assign proj.plane_u = plane_u_reg;
    assign proj.plane_v = plane_v_reg;
    assign proj.miss  = out_miss_reg;

    always_comb
    begin
        n_init = RW'(e_nm) << Q_FRAC;
        n_sat  = n_init >= (RW'(e_dm) << (W - 1));
        for (int k = 1; k <= DS; k++)
        begin
            div_trial[k] = RW'(dm_reg[k-1]) << (W - 1 - k);
            div_ge[k]    = r_reg[k-1] >= div_trial[k];
        end
        t_val = sat_reg[DS] ? {(W-1){1'b1}} : q_reg[DS];
        for (int i = 0; i < 3; i++)
        begin
            am[i] = d_reg[DS][i][W-1] ? W'(-d_reg[DS][i]) : W'(d_reg[DS][i]);
            prod[i] = (PRODW'(m1_phi_reg[i]) << HW) + PRODW'(m1_plo_reg[i]);
            if (m2_neg_reg[i])
                h_full[i] = HSW'(m2_o_reg[i]) - HSW'({1'b0, m2_term_reg[i]});
            else
                h_full[i] = HSW'(m2_o_reg[i]) + HSW'({1'b0, m2_term_reg[i]});
            if (m2_ovf_reg[i])
                h_c[i] = m2_neg_reg[i] ? C_MIN : C_MAX;
            else if (h_full[i] > HSW'(C_MAX))
                h_c[i] = C_MAX;
            else if (h_full[i] < HSW'(C_MIN))
                h_c[i] = C_MIN;
            else
                h_c[i] = W'(h_full[i]);
            pu[i] = unit_at(u_row_rotation, axis_of(i)) * m3_h_reg[i];
            pv[i] = unit_at(v_row_rotation, axis_of(i)) * m3_h_reg[i];
        end
        sum_u = OW'(u_row_offset) + OW'(u1_tu_reg[0]) + OW'(u1_tu_reg[1]) + OW'(u1_tu_reg[2]);
        sum_v = OW'(v_row_offset) + OW'(u1_tv_reg[0]) + OW'(u1_tv_reg[1]) + OW'(u1_tv_reg[2]);
        if (sum_u > OW'(C_MAX))
            u_sat = C_MAX;
        else if (sum_u < OW'(C_MIN))
            u_sat = C_MIN;
        else
            u_sat = W'(sum_u);
        if (sum_v > OW'(C_MAX))
            v_sat = C_MAX;
        else if (sum_v < OW'(C_MIN))
            v_sat = C_MIN;
        else
            v_sat = W'(sum_v);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= DS; k++)
                valid_reg[k] <= 1'b0;
            m1_valid_reg  <= 1'b0;
            m2_valid_reg  <= 1'b0;
            m3_valid_reg  <= 1'b0;
            u1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg[0] <= ent_valid;
            for (int k = 1; k <= DS; k++)
                valid_reg[k] <= valid_reg[k-1];
            m1_valid_reg  <= valid_reg[DS];
            m2_valid_reg  <= m1_valid_reg;
            m3_valid_reg  <= m2_valid_reg;
            u1_valid_reg  <= m3_valid_reg;
            out_valid_reg <= u1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cmd_reg[0]  <= e_cmd;
            miss_reg[0] <= e_miss;
            sat_reg[0]  <= n_sat;
            r_reg[0]    <= n_init;
            q_reg[0]    <= '0;
            dm_reg[0]   <= e_dm;
            for (int i = 0; i < 3; i++)
            begin
                o_reg[0][i] <= e_o[i];
                d_reg[0][i] <= e_d[i];
            end
            for (int k = 1; k <= DS; k++)
            begin
                cmd_reg[k]  <= cmd_reg[k-1];
                miss_reg[k] <= miss_reg[k-1];
                sat_reg[k]  <= sat_reg[k-1];
                dm_reg[k]   <= dm_reg[k-1];
                r_reg[k]    <= div_ge[k] ? r_reg[k-1] - div_trial[k] : r_reg[k-1];
                q_reg[k]    <= q_reg[k-1] |
                               (div_ge[k] ? ((W-1)'(1) << (W - 1 - k)) : '0);
                for (int i = 0; i < 3; i++)
                begin
                    o_reg[k][i] <= o_reg[k-1][i];
                    d_reg[k][i] <= d_reg[k-1][i];
                end
            end

            m1_cmd_reg  <= cmd_reg[DS];
            m1_miss_reg <= miss_reg[DS];
            m2_cmd_reg  <= m1_cmd_reg;
            m2_miss_reg <= m1_miss_reg;
            m3_cmd_reg  <= m2_cmd_reg;
            m3_miss_reg <= m2_miss_reg;
            u1_cmd_reg  <= m3_cmd_reg;
            u1_miss_reg <= m3_miss_reg;
            for (int i = 0; i < 3; i++)
            begin
                m1_plo_reg[i]  <= t_val[HW-1:0] * am[i];
                m1_phi_reg[i]  <= t_val[W-2:HW] * am[i];
                m1_neg_reg[i]  <= d_reg[DS][i][W-1];
                m1_o_reg[i]    <= o_reg[DS][i];
                m2_term_reg[i] <= prod[i][PRODW-1:Q_FRAC];
                m2_ovf_reg[i]  <= (prod[i] >> PROD_LIMIT_BITS) != '0;
                m2_neg_reg[i]  <= m1_neg_reg[i];
                m2_o_reg[i]    <= m1_o_reg[i];
                m3_h_reg[i]    <= h_c[i];
                u1_tu_reg[i]   <= TW'(pu[i] >>> UNIT_FRAC);
                u1_tv_reg[i]   <= TW'(pv[i] >>> UNIT_FRAC);
            end

            out_miss_reg <= u1_miss_reg;
            if (u1_miss_reg)
            begin
                plane_u_reg <= (u1_cmd_reg == CMD_DIR) ? SENT_NEG : SENT_POS;
                plane_v_reg <= (u1_cmd_reg == CMD_DIR) ? SENT_NEG : SENT_POS;
            end
            else
            begin
                plane_u_reg <= u_sat;
                plane_v_reg <= v_sat;
            end
        end
    end

endmodule

`default_nettype wire

// ===== design/ray_plane_project_2d_unit.sv =====
// top level: configuration registers, front end, queue and back end
// throughput: one ray per cycle while proj.ready does not stall the output
// the divide for t is a pipeline of COORD_WIDTH-1 stages
// front and back stall separately through a two-entry queue
// reset: asynchronous active-low rst_n empties all pipelines and restores register defaults
// configuration writes are always accepted
`timescale 1ns / 1ps
`default_nettype none

module ray_plane_project_2d_unit
    import rpp2d_pkg::*;
#(
    parameter int COORD_WIDTH = 32
)
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    rpp2d_ray_if.sink    ray,
    rpp2d_proj_if.source proj,
    rpp2d_cfg_if.sink    cfg
);

    localparam int W      = COORD_WIDTH;
    localparam int ENT_W  = 8 * W + 11;

    logic [ROT_W-1:0]    plane_normal_reg;
    logic signed [W-1:0] plane_offset_reg;
    logic [ROT_W-1:0]    u_row_rotation_reg;
    logic signed [W-1:0] u_row_offset_reg;
    logic [ROT_W-1:0]    v_row_rotation_reg;
    logic signed [W-1:0] v_row_offset_reg;

    logic             f_valid, f_ready;
    logic [ENT_W-1:0] f_data;
    logic             b_valid, b_ready;
    logic [ENT_W-1:0] b_data;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plane_normal_reg   <= NORMAL_RESET;
            plane_offset_reg   <= '0;
            u_row_rotation_reg <= '0;
            u_row_offset_reg   <= '0;
            v_row_rotation_reg <= '0;
            v_row_offset_reg   <= '0;
        end
        else if (cfg.valid)
        begin
            case (cfg_reg_t'(cfg.index))
                REG_PLANE_NORMAL:   plane_normal_reg   <= cfg.data[ROT_W-1:0];
                REG_PLANE_OFFSET:   plane_offset_reg   <= cfg.data[W-1:0];
                REG_U_ROW_ROTATION: u_row_rotation_reg <= cfg.data[ROT_W-1:0];
                REG_U_ROW_OFFSET:   u_row_offset_reg   <= cfg.data[W-1:0];
                REG_V_ROW_ROTATION: v_row_rotation_reg <= cfg.data[ROT_W-1:0];
                REG_V_ROW_OFFSET:   v_row_offset_reg   <= cfg.data[W-1:0];
                default:            ;
            endcase
        end
    end

    rpp2d_front #(.COORD_WIDTH(W)) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .ray          (ray),
        .plane_normal (plane_normal_reg),
        .plane_offset (plane_offset_reg),
        .ent_valid    (f_valid),
        .ent_ready    (f_ready),
        .ent_data     (f_data)
    );

    rpp2d_queue #(.DATA_W(ENT_W)) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_data   (f_data),
        .out_valid (b_valid),
        .out_ready (b_ready),
        .out_data  (b_data)
    );

    rpp2d_back #(.COORD_WIDTH(W)) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .ent_valid      (b_valid),
        .ent_ready      (b_ready),
        .ent_data       (b_data),
        .u_row_rotation (u_row_rotation_reg),
        .u_row_offset   (u_row_offset_reg),
        .v_row_rotation (v_row_rotation_reg),
        .v_row_offset   (v_row_offset_reg),
        .proj           (proj)
    );

endmodule

`default_nettype wire

// ===== design/rpp2d_checker.sv =====
// checker: port-level assertions on the projection unit, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module rpp2d_checker
    import rpp2d_pkg::*;
#(
    parameter int COORD_WIDTH = 32
)
(
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          cfg_ready,
    input wire logic                          out_valid,
    input wire logic                          out_ready,
    input wire logic signed [COORD_WIDTH-1:0] plane_u,
    input wire logic signed [COORD_WIDTH-1:0] plane_v,
    input wire logic                          miss
);

    localparam int W = COORD_WIDTH;
    localparam logic signed [W-1:0] C_MAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] C_MIN = {1'b1, {(W-1){1'b0}}};
    localparam logic signed [W-1:0] SENT_POS =
        (SENTINEL_MAG <= ((64'sd1 <<< (W - 1)) - 64'sd1)) ? W'(SENTINEL_MAG) : C_MAX;
    localparam logic signed [W-1:0] SENT_NEG =
        (SENTINEL_MAG <= (64'sd1 <<< (W - 1))) ? W'(-SENTINEL_MAG) : C_MIN;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(plane_u) && $stable(plane_v) && $stable(miss))
        else $error("result changed while stalled");

    a_miss_sentinel: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && miss |-> (plane_u == plane_v) &&
                              (plane_u == SENT_POS || plane_u == SENT_NEG))
        else $error("miss result without sentinel");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("configuration channel not ready");

endmodule

bind ray_plane_project_2d_unit rpp2d_checker #(.COORD_WIDTH(COORD_WIDTH)) u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_ready (cfg.ready),
    .out_valid (proj.valid),
    .out_ready (proj.ready),
    .plane_u   (proj.plane_u),
    .plane_v   (proj.plane_v),
    .miss      (proj.miss)
);

`default_nettype wire

// ===== bench/ray_plane_project_2d_unit_test.sv =====
// testbench: ray-plane projection unit checked against a built-in predictor over config phases
`timescale 1ns / 1ps

module ray_plane_project_2d_unit_test;
    import rpp2d_pkg::*;

    localparam int CW = 32;
    localparam longint CMAX = (64'sd1 <<< (CW - 1)) - 1;
    localparam longint CYCLE_LIMIT = 3000000;

    typedef struct {
        logic                 command;
        logic signed [CW-1:0] o [3];
        logic signed [CW-1:0] s [3];
    } ray_t;

    typedef struct {
        logic signed [CW-1:0] u;
        logic signed [CW-1:0] v;
        logic                 miss;
    } proj_t;

    logic clk;
    logic rst_n;

    rpp2d_ray_if #(.COORD_WIDTH(CW))  ray_bus ();
    rpp2d_proj_if #(.COORD_WIDTH(CW)) proj_bus ();
    rpp2d_cfg_if                      cfg_bus ();

    ray_plane_project_2d_unit #(.COORD_WIDTH(CW)) DUT
    (
        .clk   (clk),
        .rst_n (rst_n),
        .ray   (ray_bus),
        .proj  (proj_bus),
        .cfg   (cfg_bus)
    );

    logic [ROT_W-1:0] normal_r, u_rot_r, v_rot_r;
    longint           plane_off_r, u_off_r, v_off_r;

    ray_t   pending_rays [$];
    proj_t  expected_proj [$];
    int     send_idle_pct;
    int     recv_stall_pct;
    int     mismatches;
    longint cycles;
    bit     ray_taken;

    function automatic longint sat_coord(input longint x);
        if (x > CMAX)
            return CMAX;
        if (x < -CMAX - 1)
            return -CMAX - 1;
        return x;
    endfunction

    function automatic longint unit_dot(input logic [ROT_W-1:0] p, input longint a,
                                        input longint b, input longint c);
        longint ux, uy, uz;
        ux = longint'($signed(p[47:32]));
        uy = longint'($signed(p[31:16]));
        uz = longint'($signed(p[15:0]));
        return ((ux * a) >>> UNIT_FRAC) + ((uy * b) >>> UNIT_FRAC) + ((uz * c) >>> UNIT_FRAC);
    endfunction

    function automatic longint unsigned magnitude(input longint x);
        return (x < 0) ? longint'(-x) : longint'(x);
    endfunction

    function automatic proj_t project_ray(input ray_t r);
        proj_t                res;
        longint               o [3];
        longint               d [3];
        longint               h [3];
        longint               dn, num, sent, term;
        longint unsigned      nm, dm, q, rm, tm, am, tmax;
        bit                   dir_mode;
        for (int i = 0; i < 3; i++)
        begin
            o[i] = longint'(r.o[i]);
        end
        dir_mode = (r.command == CMD_DIR);
        for (int i = 0; i < 3; i++)
        begin
            d[i] = dir_mode ? longint'(r.s[i]) : sat_coord(longint'(r.s[i]) - o[i]);
        end
        dn  = unit_dot(normal_r, d[0], d[1], d[2]);
        num = plane_off_r - unit_dot(normal_r, o[0], o[1], o[2]);
        if (dn == 0 || (!dir_mode && dn > 0) || (num != 0 && ((num < 0) != (dn < 0))))
        begin
            sent = sat_coord(dir_mode ? -SENTINEL_MAG : SENTINEL_MAG);
            res.u    = sent[CW-1:0];
            res.v    = sent[CW-1:0];
            res.miss = 1'b1;
            return res;
        end
        nm   = magnitude(num);
        dm   = magnitude(dn);
        tmax = CMAX;
        q    = nm / dm;
        rm   = nm % dm;
        if (q > (tmax >> Q_FRAC))
            tm = tmax;
        else
        begin
            for (int i = 0; i < Q_FRAC; i++)
            begin
                rm = rm << 1;
                q  = q << 1;
                if (rm >= dm)
                begin
                    rm = rm - dm;
                    q  = q | 1;
                end
            end
            tm = (q > tmax) ? tmax : q;
        end
        for (int i = 0; i < 3; i++)
        begin
            am = magnitude(d[i]);
            if (am != 0 && tm > 64'h7FFF_FFFF_FFFF_FFFF / am)
                term = 2 * CMAX + 2;
            else
                term = longint'((tm * am) >> Q_FRAC);
            if (d[i] < 0)
                term = -term;
            h[i] = sat_coord(o[i] + term);
        end
        res.u    = CW'(sat_coord(u_off_r + unit_dot(u_rot_r, h[0], h[1], h[2])));
        res.v    = CW'(sat_coord(v_off_r + unit_dot(v_rot_r, h[0], h[1], h[2])));
        res.miss = 1'b0;
        return res;
    endfunction

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #10 clk = ~clk;
        end
    end

    // driver
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!ray_bus.valid || ray_taken)
            begin
                ray_taken = 1'b0;
                if (pending_rays.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    ray_t r;
                    r = pending_rays.pop_front();
                    ray_bus.command <= r.command;
                    ray_bus.origin_x <= r.o[0];
                    ray_bus.origin_y <= r.o[1];
                    ray_bus.origin_z <= r.o[2];
                    ray_bus.second_x <= r.s[0];
                    ray_bus.second_y <= r.s[1];
                    ray_bus.second_z <= r.s[2];
                    ray_bus.valid <= 1'b1;
                end
                else
                    ray_bus.valid <= 1'b0;
            end
            proj_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // monitor
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
        if (rst_n && ray_bus.valid && ray_bus.ready)
        begin
            ray_t r;
            r.command = ray_bus.command;
            r.o[0] = ray_bus.origin_x;
            r.o[1] = ray_bus.origin_y;
            r.o[2] = ray_bus.origin_z;
            r.s[0] = ray_bus.second_x;
            r.s[1] = ray_bus.second_y;
            r.s[2] = ray_bus.second_z;
            expected_proj.push_back(project_ray(r));
            ray_taken = 1'b1;
        end
        if (rst_n && proj_bus.valid && proj_bus.ready)
        begin
            if (expected_proj.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected transaction: u=%0d v=%0d miss=%0b",
                             proj_bus.plane_u, proj_bus.plane_v, proj_bus.miss);
            end
            else
            begin
                proj_t e;
                e = expected_proj.pop_front();
                if (e.u !== proj_bus.plane_u || e.v !== proj_bus.plane_v
                    || e.miss !== proj_bus.miss)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected u=%0d v=%0d miss=%0b, got u=%0d v=%0d miss=%0b",
                                 e.u, e.v, e.miss, proj_bus.plane_u, proj_bus.plane_v,
                                 proj_bus.miss);
                end
            end
        end
    end

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_bus.index <= idx;
        cfg_bus.data  <= value;
        cfg_bus.valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_bus.ready);
        case (idx)
            REG_PLANE_NORMAL:   normal_r = value;
            REG_PLANE_OFFSET:   plane_off_r = longint'($signed(value[CW-1:0]));
            REG_U_ROW_ROTATION: u_rot_r = value;
            REG_U_ROW_OFFSET:   u_off_r = longint'($signed(value[CW-1:0]));
            REG_V_ROW_ROTATION: v_rot_r = value;
            REG_V_ROW_OFFSET:   v_off_r = longint'($signed(value[CW-1:0]));
            default: ;
        endcase
        @(negedge clk);
        cfg_bus.valid <= 1'b0;
    endtask

    task automatic write_all(input logic [47:0] n, input logic [31:0] off,
                             input logic [47:0] ur, input logic [31:0] uo,
                             input logic [47:0] vr, input logic [31:0] vo);
        write_reg(REG_PLANE_NORMAL, n);
        write_reg(REG_PLANE_OFFSET, {16'd0, off});
        write_reg(REG_U_ROW_ROTATION, ur);
        write_reg(REG_U_ROW_OFFSET, {16'd0, uo});
        write_reg(REG_V_ROW_ROTATION, vr);
        write_reg(REG_V_ROW_OFFSET, {16'd0, vo});
    endtask

    function automatic logic signed [CW-1:0] pick_coord();
        case ($urandom_range(9))
            0, 1, 2: return $urandom();
            3:       return $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            4:       return $signed($urandom_range(255)) - 128;
            default: return $signed($urandom_range(32'h0FF_FFFF)) - 32'sh80_0000;
        endcase
    endfunction

    function automatic logic [15:0] pick_unit();
        case ($urandom_range(5))
            0:       return 16'($urandom());
            1:       return 16'sd16384;
            2:       return -16'sd16384;
            3:       return 16'd0;
            default: return 16'($signed($urandom_range(32767)) - 16384);
        endcase
    endfunction

    function automatic ray_t make_ray(input logic cmd, input logic signed [CW-1:0] ox,
                                      input logic signed [CW-1:0] oy,
                                      input logic signed [CW-1:0] oz,
                                      input logic signed [CW-1:0] sx,
                                      input logic signed [CW-1:0] sy,
                                      input logic signed [CW-1:0] sz);
        ray_t r;
        r.command = cmd;
        r.o[0] = ox; r.o[1] = oy; r.o[2] = oz;
        r.s[0] = sx; r.s[1] = sy; r.s[2] = sz;
        return r;
    endfunction

    task automatic queue_directed();
        localparam logic signed [CW-1:0] ONE = 32'sh1_0000;
        localparam logic signed [CW-1:0] MX = 32'sh7FFF_FFFF;
        localparam logic signed [CW-1:0] MN = 32'sh8000_0000;
        // facing, parallel, behind, zero t
        pending_rays.push_back(make_ray(CMD_POINT, 0, 0, -ONE, ONE, ONE, ONE));
        pending_rays.push_back(make_ray(CMD_POINT, 0, 0, ONE, 0, 0, -ONE));
        pending_rays.push_back(make_ray(CMD_POINT, 0, 0, ONE, 5, 7, ONE));
        pending_rays.push_back(make_ray(CMD_DIR, 0, 0, ONE, 5, 7, 0));
        pending_rays.push_back(make_ray(CMD_DIR, 0, 0, -ONE, 0, 0, -ONE));
        pending_rays.push_back(make_ray(CMD_DIR, 3, 4, 0, ONE, ONE, ONE));
        pending_rays.push_back(make_ray(CMD_POINT, 3, 4, 0, ONE, -ONE, -ONE));
        pending_rays.push_back(make_ray(CMD_DIR, ONE, 2 * ONE, -ONE, ONE, -ONE, ONE));
        pending_rays.push_back(make_ray(CMD_POINT, ONE, ONE, 3 * ONE, -ONE, 2 * ONE, -ONE));
        // large t and saturated direction
        pending_rays.push_back(make_ray(CMD_DIR, 0, 0, MN, MX, MN, 1));
        pending_rays.push_back(make_ray(CMD_DIR, MX, MN, MN, 1, 1, 1));
        pending_rays.push_back(make_ray(CMD_POINT, MX, MX, MX, MN, MN, MN));
        pending_rays.push_back(make_ray(CMD_POINT, MN, MN, MX, MX, MX, MN));
        pending_rays.push_back(make_ray(CMD_DIR, MX, MX, MX, MX, MX, MX));
        pending_rays.push_back(make_ray(CMD_DIR, MN, MN, MN, MN, MN, MN));
        pending_rays.push_back(make_ray(CMD_POINT, -1, -1, -1, 0, 0, MN));
        pending_rays.push_back(make_ray(CMD_DIR, 0, 0, 0, 0, 0, 0));
        pending_rays.push_back(make_ray(CMD_POINT, 0, 0, 0, 0, 0, 0));
        pending_rays.push_back(make_ray(CMD_DIR, 0, 0, 1, 0, 0, -1));
        pending_rays.push_back(make_ray(CMD_POINT, MN, 0, MX, 0, MX, MN));
    endtask

    task automatic queue_random(input int count);
        ray_t  r;
        proj_t p;
        bit    want_hit;
        for (int k = 0; k < count; k++)
        begin
            r.command = $urandom_range(1);
            for (int i = 0; i < 3; i++)
            begin
                r.o[i] = pick_coord();
                r.s[i] = pick_coord();
            end
            want_hit = ($urandom_range(99) < 75);
            for (int tries = 0; want_hit && tries < 8; tries++)
            begin
                p = project_ray(r);
                if (!p.miss)
                    break;
                if (tries[0])
                begin
                    for (int i = 0; i < 3; i++)
                        r.s[i] = r.command ? -r.s[i] : 2 * r.o[i] - r.s[i];
                end
                else
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        r.o[i] = $signed($urandom_range(32'h3FF_FFFF)) - 32'sh200_0000;
                        r.s[i] = $signed($urandom_range(32'h3FF_FFFF)) - 32'sh200_0000;
                    end
                end
            end
            pending_rays.push_back(r);
        end
    endtask

    task automatic drain();
        wait (pending_rays.size() == 0 && !ray_bus.valid && expected_proj.size() == 0);
        repeat (60) @(posedge clk);
    endtask

    initial
    begin
        rst_n = 1'b0;
        ray_bus.valid = 1'b0;
        ray_bus.command = CMD_POINT;
        ray_bus.origin_x = '0;
        ray_bus.origin_y = '0;
        ray_bus.origin_z = '0;
        ray_bus.second_x = '0;
        ray_bus.second_y = '0;
        ray_bus.second_z = '0;
        proj_bus.ready = 1'b0;
        cfg_bus.valid = 1'b0;
        cfg_bus.index = REG_PLANE_NORMAL;
        cfg_bus.data = '0;
        ray_taken = 1'b0;
        mismatches = 0;
        cycles = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        normal_r = NORMAL_RESET;
        plane_off_r = 0;
        u_rot_r = '0;
        u_off_r = 0;
        v_rot_r = '0;
        v_off_r = 0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        queue_directed();
        queue_random(60);
        drain();

        write_all(48'h0000_0000_4000, 32'sh0, 48'h4000_0000_0000, 32'sh1234,
                  48'h0000_4000_0000, -32'sh8765);
        queue_directed();
        for (int ph = 0; ph < 10; ph++)
        begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 77; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 77; end
                default: begin send_idle_pct = 20; recv_stall_pct = 20; end
            endcase
            if (ph == 3)
                write_all(48'hFFFF_FFFF_FFFF, 32'sh7FFF_FFFF, 48'hFFFF_FFFF_FFFF,
                          32'sh7FFF_FFFF, 48'hFFFF_FFFF_FFFF, 32'sh7FFF_FFFF);
            else if (ph == 6)
                write_all(48'h8000_8000_8000, 32'sh8000_0000, 48'h8000_8000_8000,
                          32'sh8000_0000, 48'h7FFF_7FFF_7FFF, 32'sh8000_0000);
            else if (ph > 0)
            begin
                write_all({pick_unit(), pick_unit(), pick_unit()}, pick_coord(),
                          {pick_unit(), pick_unit(), pick_unit()}, pick_coord(),
                          {pick_unit(), pick_unit(), pick_unit()}, pick_coord());
                // unused index, must be ignored
                write_reg(cfg_reg_t'(3'd6), 48'hFFFF_FFFF_FFFF);
            end
            if (ph == 9)
                queue_directed();
            queue_random(125);
            drain();
        end

        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
